// ===== rtl/sio_pkg.sv =====
`default_nettype none

package sio_pkg;

    localparam int NumBytes = 16;
    localparam int IdxW     = 8;
    localparam int PtrW     = $clog2(NumBytes);

    localparam logic [7:0] UNLOCK_KEY    = 8'h55;
    localparam logic [7:0] LOCK_KEY      = 8'hAA;
    localparam logic [7:0] CHIP_ID_RESET = 8'h65;
    localparam logic [PtrW-1:0] CHIP_ID_BYTE = PtrW'(13);

    localparam logic [2:0] ADDR_CHIP_ID = 3'd0;

    localparam logic [7:0] BYTE_RESET [NumBytes] = '{
        8'h3A, 8'h9F, 8'hDC, 8'h78, 8'h00, 8'h00, 8'hFF, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, CHIP_ID_RESET, 8'h01, 8'h00
    };

    localparam logic [9:0] COM1_BASE = 10'h3F8;
    localparam logic [9:0] COM2_BASE = 10'h2F8;
    localparam logic [9:0] THIRD_BASE  [4] = '{10'h338, 10'h3E8, 10'h3E8, 10'h220};
    localparam logic [9:0] FOURTH_BASE [4] = '{10'h238, 10'h2E8, 10'h2E0, 10'h228};
    localparam logic [9:0] LPT_BASE    [4] = '{10'h000, 10'h3BC, 10'h378, 10'h278};
    localparam logic [9:0] FDC_BASE_PRI = 10'h3F0;
    localparam logic [9:0] FDC_BASE_SEC = 10'h370;
    localparam logic [3:0] IRQ_ODD  = 4'd4;
    localparam logic [3:0] IRQ_EVEN = 4'd3;

    typedef struct packed {
        logic       opcode;
        logic       port_select;
        logic [7:0] write_data;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       config_mode;
        logic       uart_a_enable;
        logic [9:0] uart_a_base;
        logic [3:0] uart_a_irq;
        logic       uart_b_enable;
        logic [9:0] uart_b_base;
        logic [3:0] uart_b_irq;
        logic [9:0] lpt_base;
        logic       fdc_enable;
        logic [9:0] fdc_base;
        logic [3:0] fdc_control;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic index_wr;
        logic data_wr;
        logic data_rd;
        logic mode;
    } cmd_t;

    typedef struct packed {
        logic write;
        logic data_port;
        logic unlock_key;
        logic lock_key;
    } status_t;

    typedef enum logic [2:0] {
        ST_LOCKED = 3'b001,
        ST_KEY1   = 3'b010,
        ST_OPEN   = 3'b100
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/superio_config_register_block_unit.sv =====
// channel    dir  handshake             payload
// request    in   req_valid/req_stall   req   (opcode, port_select, write_data)
// response   out  rsp_valid/rsp_stall   rsp   (read_data, config_mode, decodes)
// config     in   APB psel/penable      paddr[2:0], pwdata, prdata
//
// One request per cycle while req_stall is low; its response shows on rsp the cycle after acceptance.
// The response register is the only stage; req_stall follows a stalled response.
// Reset clears lock state, index and the config bytes to their defaults.
// Decoded fields reflect the config bytes after the request is applied.
`default_nettype none

module superio_config_register_block_unit
    import sio_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire req_t        req,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output rsp_t             rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    cmd_t       cmd;
    status_t    status;
    logic       cfg_wr;
    logic [7:0] chip_id;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr == ADDR_CHIP_ID);
    assign prdata = (paddr == ADDR_CHIP_ID) ? {24'h000000, chip_id} : 32'h0;

    sio_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    sio_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cmd      (cmd),
        .status   (status),
        .cfg_wr   (cfg_wr),
        .cfg_data (pwdata[7:0]),
        .chip_id  (chip_id),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

// ===== rtl/sio_ctrl.sv =====
`default_nettype none

module sio_ctrl
    import sio_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    req_valid,
    output logic         req_stall,
    output logic         rsp_valid,
    input  wire logic    rsp_stall,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   accept;

    assign req_stall = rsp_valid_reg & rsp_stall;
    assign accept    = req_valid & ~req_stall;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.capture  = accept;
        if (accept)
        begin
            unique case (state_reg)
                ST_OPEN:
                begin
                    if (status.write && !status.data_port)
                    begin
                        if (status.lock_key)
                            state_next = ST_LOCKED;
                        else
                            cmd.index_wr = 1'b1;
                    end
                    else if (status.write)
                        cmd.data_wr = 1'b1;
                    else if (status.data_port)
                        cmd.data_rd = 1'b1;
                end
                ST_KEY1:
                begin
                    if (status.write && !status.data_port && status.unlock_key)
                        state_next = ST_OPEN;
                end
                ST_LOCKED:
                begin
                    if (status.write && !status.data_port && status.unlock_key)
                        state_next = ST_KEY1;
                end
                default:
                    state_next = ST_LOCKED;
            endcase
        end
        cmd.mode = (state_next == ST_OPEN);
    end

    assign rsp_valid_next = accept | (rsp_valid_reg & rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOCKED;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sio_datapath.sv =====
`default_nettype none

module sio_datapath
    import sio_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire req_t        req,
    input  wire cmd_t        cmd,
    output status_t          status,
    input  wire logic        cfg_wr,
    input  wire logic [7:0]  cfg_data,
    output logic      [7:0]  chip_id,
    output rsp_t             rsp
);

    logic [7:0]      bytes_reg [NumBytes];
    logic [7:0]      bytes_next [NumBytes];
    logic [IdxW-1:0] idx_reg, idx_next;
    logic [7:0]      chip_id_reg, chip_id_next;
    rsp_t            rsp_reg, rsp_next;
    logic            in_range;
    logic [PtrW-1:0] ptr;

    function automatic void decode_uart(input logic [1:0] sel, input logic en,
                                        input logic [1:0] pair,
                                        output logic [9:0] base,
                                        output logic [3:0] irq);
        base = '0;
        irq  = '0;
        if (en)
        begin
            unique case (sel)
                2'd0:
                begin
                    base = COM1_BASE;
                    irq  = IRQ_ODD;
                end
                2'd1:
                begin
                    base = COM2_BASE;
                    irq  = IRQ_EVEN;
                end
                2'd2:
                begin
                    base = THIRD_BASE[pair];
                    irq  = IRQ_ODD;
                end
                default:
                begin
                    base = FOURTH_BASE[pair];
                    irq  = IRQ_EVEN;
                end
            endcase
        end
    endfunction

    assign status.write      = req.opcode;
    assign status.data_port  = req.port_select;
    assign status.unlock_key = (req.write_data == UNLOCK_KEY);
    assign status.lock_key   = (req.write_data == LOCK_KEY);

    assign in_range = (idx_reg[IdxW-1:PtrW] == '0);
    assign ptr      = idx_reg[PtrW-1:0];

    always_comb
    begin
        bytes_next   = bytes_reg;
        idx_next     = idx_reg;
        chip_id_next = chip_id_reg;
        if (cfg_wr)
        begin
            chip_id_next             = cfg_data;
            bytes_next[CHIP_ID_BYTE] = cfg_data;
        end
        if (cmd.index_wr)
            idx_next = req.write_data;
        if (cmd.data_wr && in_range)
            bytes_next[ptr] = req.write_data;
    end

    always_comb
    begin
        rsp_next             = '0;
        rsp_next.read_data   = (cmd.data_rd && in_range) ? bytes_reg[ptr] : 8'h00;
        rsp_next.config_mode = cmd.mode;
        rsp_next.uart_a_enable = bytes_next[2][2];
        decode_uart(bytes_next[2][1:0], bytes_next[2][2], bytes_next[1][6:5],
                    rsp_next.uart_a_base, rsp_next.uart_a_irq);
        rsp_next.uart_b_enable = bytes_next[2][6];
        decode_uart(bytes_next[2][5:4], bytes_next[2][6], bytes_next[1][6:5],
                    rsp_next.uart_b_base, rsp_next.uart_b_irq);
        rsp_next.lpt_base    = LPT_BASE[bytes_next[1][1:0]];
        rsp_next.fdc_enable  = bytes_next[0][4];
        rsp_next.fdc_base    = bytes_next[0][4]
                             ? (bytes_next[5][0] ? FDC_BASE_SEC : FDC_BASE_PRI)
                             : 10'h000;
        rsp_next.fdc_control = {bytes_next[5][5], bytes_next[5][4:3], bytes_next[3][1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg   <= BYTE_RESET;
            idx_reg     <= '0;
            chip_id_reg <= CHIP_ID_RESET;
        end
        else
        begin
            bytes_reg   <= bytes_next;
            idx_reg     <= idx_next;
            chip_id_reg <= chip_id_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            rsp_reg <= rsp_next;
    end

    assign rsp     = rsp_reg;
    assign chip_id = chip_id_reg;

endmodule

`default_nettype wire

// ===== rtl/sio_checker.sv =====
`default_nettype none

module sio_checker
    import sio_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_stall,
    input wire logic rsp_valid,
    input wire logic rsp_stall,
    input wire rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    a_req_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> rsp_valid)
        else $error("accepted request gave no response");

    a_read_unlocked: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.read_data != 8'h00) |-> rsp.config_mode)
        else $error("nonzero read data while locked");

    a_uart_off: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.uart_a_enable |-> rsp.uart_a_base == 10'h000
                                          && rsp.uart_a_irq == 4'h0)
        else $error("disabled serial port shows base or irq");

endmodule

bind superio_config_register_block_unit sio_checker u_sio_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import sio_pkg::*;

    localparam logic OP_READ    = 1'b0;
    localparam logic OP_WRITE   = 1'b1;
    localparam logic PORT_INDEX = 1'b0;
    localparam logic PORT_DATA  = 1'b1;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 60;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_t        req       = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_t        rsp;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the block's state
    logic [7:0] cfg_bytes [16];
    logic [1:0] unlock_cnt;
    logic [7:0] reg_idx;
    logic [7:0] chip_id_val;

    rsp_t responses_due [$];
    rsp_t want;

    int   requests_sent  = 0;
    int   responses_seen = 0;
    int   id_settings    = 0;
    int   mismatches     = 0;
    int   cycles         = 0;
    logic quiet_run      = 1'b0;

    superio_config_register_block_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
    endtask

    task automatic reset_model();
        int i;
        for (i = 0; i < 16; i++)
            cfg_bytes[i] = 8'h00;
        cfg_bytes[0]  = 8'h3A;
        cfg_bytes[1]  = 8'h9F;
        cfg_bytes[2]  = 8'hDC;
        cfg_bytes[3]  = 8'h78;
        cfg_bytes[6]  = 8'hFF;
        cfg_bytes[14] = 8'h01;
        chip_id_val   = 8'h65;
        cfg_bytes[13] = chip_id_val;
        unlock_cnt    = 2'd0;
        reg_idx       = 8'h00;
    endtask

    function automatic void serial_decode(input logic [1:0] sel, input logic en,
                                          output logic [9:0] base,
                                          output logic [3:0] irq);
        logic [1:0] pair;
        pair = cfg_bytes[1][6:5];
        base = 10'h000;
        irq  = 4'd0;
        if (en)
        begin
            case (sel)
                2'd0: begin base = 10'h3F8; irq = 4'd4; end
                2'd1: begin base = 10'h2F8; irq = 4'd3; end
                2'd2:
                begin
                    irq = 4'd4;
                    case (pair)
                        2'd0: base = 10'h338;
                        2'd1: base = 10'h3E8;
                        2'd2: base = 10'h3E8;
                        default: base = 10'h220;
                    endcase
                end
                default:
                begin
                    irq = 4'd3;
                    case (pair)
                        2'd0: base = 10'h238;
                        2'd1: base = 10'h2E8;
                        2'd2: base = 10'h2E0;
                        default: base = 10'h228;
                    endcase
                end
            endcase
        end
    endfunction

    // applies one bus access to the shadow state and returns the decoded outputs
    function automatic rsp_t apply_access(input req_t r);
        rsp_t       o;
        logic       unlocked;
        logic [7:0] r5;
        o = '0;
        unlocked = (unlock_cnt == 2'd2);
        if (r.opcode == OP_WRITE)
        begin
            if (unlocked)
            begin
                if (r.port_select == PORT_INDEX)
                begin
                    if (r.write_data == LOCK_KEY)
                        unlock_cnt = 2'd0;
                    else
                        reg_idx = r.write_data;
                end
                else if (reg_idx < 8'd16)
                    cfg_bytes[reg_idx[3:0]] = r.write_data;
            end
            else if (r.port_select == PORT_INDEX && r.write_data == UNLOCK_KEY)
                unlock_cnt = unlock_cnt + 2'd1;
        end
        else if (unlocked && r.port_select == PORT_DATA && reg_idx < 8'd16)
            o.read_data = cfg_bytes[reg_idx[3:0]];

        o.config_mode   = (unlock_cnt == 2'd2);
        o.uart_a_enable = cfg_bytes[2][2];
        serial_decode(cfg_bytes[2][1:0], cfg_bytes[2][2], o.uart_a_base, o.uart_a_irq);
        o.uart_b_enable = cfg_bytes[2][6];
        serial_decode(cfg_bytes[2][5:4], cfg_bytes[2][6], o.uart_b_base, o.uart_b_irq);
        case (cfg_bytes[1][1:0])
            2'd0: o.lpt_base = 10'h000;
            2'd1: o.lpt_base = 10'h3BC;
            2'd2: o.lpt_base = 10'h378;
            default: o.lpt_base = 10'h278;
        endcase
        r5 = cfg_bytes[5];
        o.fdc_enable  = cfg_bytes[0][4];
        o.fdc_base    = !o.fdc_enable ? 10'h000 : (r5[0] ? 10'h370 : 10'h3F0);
        o.fdc_control = {r5[5], r5[4:3], cfg_bytes[3][1]};
        return o;
    endfunction

    task automatic send_request(input logic op, input logic port, input logic [7:0] data);
        req_t r;
        r.opcode      = op;
        r.port_select = port;
        r.write_data  = data;
        while (!quiet_run && $urandom_range(99) < 16)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        responses_due.push_back(apply_access(r));
        requests_sent++;
    endtask

    task automatic wait_responses_drained();
        req_valid <= 1'b0;
        while (responses_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic compare_response(input rsp_t got, input rsp_t exp_r);
        if (got.read_data !== exp_r.read_data)
            report_mismatch("read_data", 32'(got.read_data), 32'(exp_r.read_data));
        if (got.config_mode !== exp_r.config_mode)
            report_mismatch("config_mode", 32'(got.config_mode), 32'(exp_r.config_mode));
        if (got.uart_a_enable !== exp_r.uart_a_enable)
            report_mismatch("uart_a_enable", 32'(got.uart_a_enable),
                            32'(exp_r.uart_a_enable));
        if (got.uart_a_base !== exp_r.uart_a_base)
            report_mismatch("uart_a_base", 32'(got.uart_a_base), 32'(exp_r.uart_a_base));
        if (got.uart_a_irq !== exp_r.uart_a_irq)
            report_mismatch("uart_a_irq", 32'(got.uart_a_irq), 32'(exp_r.uart_a_irq));
        if (got.uart_b_enable !== exp_r.uart_b_enable)
            report_mismatch("uart_b_enable", 32'(got.uart_b_enable),
                            32'(exp_r.uart_b_enable));
        if (got.uart_b_base !== exp_r.uart_b_base)
            report_mismatch("uart_b_base", 32'(got.uart_b_base), 32'(exp_r.uart_b_base));
        if (got.uart_b_irq !== exp_r.uart_b_irq)
            report_mismatch("uart_b_irq", 32'(got.uart_b_irq), 32'(exp_r.uart_b_irq));
        if (got.lpt_base !== exp_r.lpt_base)
            report_mismatch("lpt_base", 32'(got.lpt_base), 32'(exp_r.lpt_base));
        if (got.fdc_enable !== exp_r.fdc_enable)
            report_mismatch("fdc_enable", 32'(got.fdc_enable), 32'(exp_r.fdc_enable));
        if (got.fdc_base !== exp_r.fdc_base)
            report_mismatch("fdc_base", 32'(got.fdc_base), 32'(exp_r.fdc_base));
        if (got.fdc_control !== exp_r.fdc_control)
            report_mismatch("fdc_control", 32'(got.fdc_control), 32'(exp_r.fdc_control));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid === 1'b1 && !rsp_stall)
        begin
            if (responses_due.size() == 0)
                report_mismatch("response with no request pending", 32'(rsp.read_data),
                                32'd0);
            else
            begin
                want = responses_due.pop_front();
                compare_response(rsp, want);
                responses_seen++;
            end
        end
    end

    always @(posedge clk)
        rsp_stall <= !quiet_run && ($urandom_range(99) < 16);

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles", CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // block must be idle: writes chip id, then reads it back
    task automatic write_chip_id(input logic [7:0] id);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CHIP_ID;
        pwdata  <= {24'h0, id};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        chip_id_val   = id;
        cfg_bytes[13] = id;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {24'h0, chip_id_val})
            report_mismatch("chip_id readback", prdata, {24'h0, chip_id_val});
        psel    <= 1'b0;
        penable <= 1'b0;
        id_settings++;
    endtask

    task automatic unlock_config();
        send_request(OP_WRITE, PORT_INDEX, UNLOCK_KEY);
        send_request(OP_WRITE, PORT_INDEX, UNLOCK_KEY);
    endtask

    function automatic logic [7:0] pick_index();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return 8'($urandom_range(5));
        if (r < 80)
            return 8'($urandom_range(15));
        return 8'($urandom_range(255, 16));
    endfunction

    task automatic test_locked_access();
        send_request(OP_READ, PORT_DATA, 8'h00);
        send_request(OP_WRITE, PORT_DATA, 8'hFF);
        send_request(OP_WRITE, PORT_INDEX, 8'h00);
        send_request(OP_READ, PORT_INDEX, 8'hFF);
    endtask

    task automatic test_unlock_sequence();
        send_request(OP_WRITE, PORT_INDEX, UNLOCK_KEY);
        send_request(OP_WRITE, PORT_INDEX, 8'h12);
        send_request(OP_WRITE, PORT_INDEX, UNLOCK_KEY);
        send_request(OP_READ, PORT_INDEX, 8'h00);
        send_request(OP_READ, PORT_DATA, 8'h00);
    endtask

    task automatic test_register_file();
        send_request(OP_WRITE, PORT_INDEX, 8'h01);
        send_request(OP_WRITE, PORT_DATA, 8'hFF);
        send_request(OP_WRITE, PORT_INDEX, 8'h02);
        send_request(OP_WRITE, PORT_DATA, 8'hFF);
        send_request(OP_READ, PORT_DATA, 8'h00);
        send_request(OP_WRITE, PORT_DATA, 8'h00);
        send_request(OP_WRITE, PORT_INDEX, 8'hFF);
        send_request(OP_WRITE, PORT_DATA, 8'hAB);
        send_request(OP_READ, PORT_DATA, 8'h00);
        send_request(OP_WRITE, PORT_INDEX, 8'h10);
        send_request(OP_READ, PORT_DATA, 8'h00);
        send_request(OP_WRITE, PORT_INDEX, 8'h0D);
        send_request(OP_READ, PORT_DATA, 8'h00);
    endtask

    task automatic test_lock_command();
        send_request(OP_WRITE, PORT_INDEX, LOCK_KEY);
        send_request(OP_READ, PORT_DATA, 8'h00);
    endtask

    task automatic test_chip_id(input logic [7:0] id);
        wait_responses_drained();
        write_chip_id(id);
        if (unlock_cnt != 2'd2)
            unlock_config();
        send_request(OP_WRITE, PORT_INDEX, 8'h0D);
        send_request(OP_READ, PORT_DATA, 8'h00);
    endtask

    task automatic test_random_traffic(input int count);
        int stop_at;
        int pick;
        int reps;
        int k;
        stop_at = requests_sent + count;
        while (requests_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (unlock_cnt != 2'd2)
            begin
                if (pick < 80)
                    unlock_config();
                else if (pick < 90)
                begin
                    send_request(OP_WRITE, PORT_INDEX, UNLOCK_KEY);
                    send_request(1'($urandom_range(1)), 1'($urandom_range(1)),
                                 8'($urandom_range(255)));
                end
                else
                    send_request(1'($urandom_range(1)), 1'($urandom_range(1)),
                                 8'($urandom_range(255)));
            end
            else if (pick < 6)
                send_request(OP_WRITE, PORT_INDEX, LOCK_KEY);
            else if (pick < 16)
                send_request(1'($urandom_range(1)), 1'($urandom_range(1)),
                             8'($urandom_range(255)));
            else if (pick < 22)
                send_request(OP_READ, PORT_INDEX, 8'($urandom_range(255)));
            else
            begin
                send_request(OP_WRITE, PORT_INDEX, pick_index());
                reps = $urandom_range(3, 1);
                for (k = 0; k < reps; k++)
                    send_request(1'($urandom_range(1)), PORT_DATA, 8'($urandom_range(255)));
            end
        end
    endtask

    initial
    begin
        reset_model();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_locked_access();
        test_unlock_sequence();
        test_register_file();
        test_lock_command();

        test_chip_id(8'h00);
        test_random_traffic(250);
        test_chip_id(8'hFF);
        quiet_run = 1'b1;
        test_random_traffic(200);
        quiet_run = 1'b0;
        test_chip_id(8'($urandom_range(255)));
        test_random_traffic(200);
        test_chip_id(8'($urandom_range(255)));
        test_random_traffic(200);

        wait_responses_drained();
        if (responses_due.size() != 0)
            report_mismatch("responses never received", 32'(responses_due.size()), 32'd0);
        $display("Sent %0d bus accesses, checked %0d responses", requests_sent, responses_seen);
        $display("Covered lock/unlock, register file, decodes and %0d chip id settings",
                 id_settings);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
